// File: src/tsfm_pkg.sv
// shared constants, types and helpers for the two-sided fifo matcher
`default_nettype none

package tsfm_pkg;

    // queue geometry and field widths
    localparam int DEPTH      = 256;
    localparam int ID_WIDTH   = 16;
    localparam int PTR_WIDTH  = $clog2(DEPTH);
    localparam int OUT_WIDTH  = 16;

    // result codes
    typedef enum logic [1:0] {
        OUT_WAIT  = 2'd0,
        OUT_MATCH = 2'd1,
        OUT_DROP  = 2'd2
    } outcome_t;

    typedef logic [PTR_WIDTH-1:0] ptr_t;

    // circular pointer advance, wraps at DEPTH
    function automatic ptr_t ptr_advance(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/two_sided_fifo_matcher.sv
// top level of the two-sided fifo matcher: pointers, two id memories, result register
//
// Usage:
//   A request transaction (client_id, side) is taken at a rising edge where
//   start is high and busy is low. The side bit picks the own queue; the
//   opposite queue is checked first. If it holds ids, the oldest one is
//   dequeued and returned in partner_id with outcome matched. Otherwise the
//   id is appended to the own queue (outcome waiting), or dropped with
//   outcome drop when the own queue already holds DEPTH-1 ids.
//   Each result is shown for exactly one cycle with done high, the cycle
//   after the request is taken; echo_id repeats the request id.
//   The pointer update and the memory write or read are issued at the
//   accept edge; while the registered memory read data is held for the
//   result, busy is high and no new request is taken.
//   The receiver cannot stall: done is a plain one-cycle strobe.
//   Reset clears both queues' head and tail pointers, so both queues are
//   empty; memory contents are not cleared and no clearing pass is needed.
`default_nettype none

module two_sided_fifo_matcher (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [15:0]                    client_id,
    input  wire logic                           side,
    output logic                                done,
    output logic [1:0]                          outcome,
    output logic [tsfm_pkg::OUT_WIDTH-1:0]      partner_id,
    output logic [15:0]                         echo_id
);
    import tsfm_pkg::*;

    // queue pointers, index 0 side a, index 1 side b
    ptr_t head_reg [2];
    ptr_t tail_reg [2];

    // id memories
    logic [ID_WIDTH-1:0] side_a_store [DEPTH];
    logic [ID_WIDTH-1:0] side_b_store [DEPTH];
    logic [ID_WIDTH-1:0] rd_a_reg;
    logic [ID_WIDTH-1:0] rd_b_reg;

    // result registers
    logic      done_reg;
    outcome_t  outcome_reg;
    logic [15:0] echo_reg;
    logic      from_b_reg;

    logic own;
    logic other;
    logic accept;
    logic other_empty;
    logic own_full;
    logic do_match;
    logic do_enq;
    ptr_t tail_adv;
    ptr_t head_adv;
    outcome_t outcome_next;

    // request decode against the current pointers
    always_comb
    begin
        own         = side;
        other       = ~side;
        accept      = start & ~busy;
        other_empty = (head_reg[other] == tail_reg[other]);
        tail_adv    = ptr_advance(tail_reg[own]);
        head_adv    = ptr_advance(head_reg[other]);
        own_full    = (tail_adv == head_reg[own]);
        do_match    = accept & ~other_empty;
        do_enq      = accept & other_empty & ~own_full;
        if (!other_empty)
        begin
            outcome_next = OUT_MATCH;
        end
        else if (own_full)
        begin
            outcome_next = OUT_DROP;
        end
        else
        begin
            outcome_next = OUT_WAIT;
        end
    end

    // pointer and result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg[0] <= '0;
            head_reg[1] <= '0;
            tail_reg[0] <= '0;
            tail_reg[1] <= '0;
            done_reg    <= 1'b0;
            outcome_reg <= OUT_WAIT;
            from_b_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                outcome_reg <= outcome_next;
                from_b_reg  <= other;
            end
            if (do_enq)
            begin
                tail_reg[own] <= tail_adv;
            end
            if (do_match)
            begin
                head_reg[other] <= head_adv;
            end
        end
    end

    // echo of the request id
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            echo_reg <= client_id;
        end
    end

    // side a memory: enqueue writes at advanced tail, match reads at advanced head
    always_ff @(posedge clk)
    begin
        if (do_enq && !own)
        begin
            side_a_store[tail_adv] <= ID_WIDTH'(client_id);
        end
        if (do_match && own)
        begin
            rd_a_reg <= side_a_store[head_adv];
        end
    end

    // side b memory
    always_ff @(posedge clk)
    begin
        if (do_enq && own)
        begin
            side_b_store[tail_adv] <= ID_WIDTH'(client_id);
        end
        if (do_match && !own)
        begin
            rd_b_reg <= side_b_store[head_adv];
        end
    end

    // result ports
    assign busy       = done_reg;
    assign done       = done_reg;
    assign outcome    = outcome_reg;
    assign echo_id    = echo_reg;
    assign partner_id = (outcome_reg == OUT_MATCH)
                      ? OUT_WIDTH'(from_b_reg ? rd_b_reg : rd_a_reg)
                      : '0;

endmodule

`default_nettype wire
